// File: hw/rtl/upr_pkg.sv
// shared types and constants for the upload frame receiver
package upr_pkg;

    localparam int unsigned CODE_IDX_W = 10;
    localparam int unsigned FRAME_LEN_W = 11;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [15:0] CODE_MAX = 16'd1024;

    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_ONE = 8'h31;

    localparam logic [31:0] HUNT_FOREVER = 32'hFFFF_FFFF;
    localparam logic [31:0] HUNT_WINDOW_RST = 32'd15000;
    localparam logic [15:0] BYTE_WAIT_RST = 16'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUNT_WINDOW = 1'b0,
        CFG_BYTE_WAIT   = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        KIND_CODE   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSTART = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_SUM     = 3'd4,
        ST_TIMEOUT = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_MAG_V  = 3'd1,
        PH_MAG_M  = 3'd2,
        PH_MAG_1  = 3'd3,
        PH_LEN_LO = 3'd4,
        PH_LEN_HI = 3'd5,
        PH_CODE   = 3'd6,
        PH_SUM    = 3'd7
    } t_phase;

    typedef struct packed {
        logic                   kind;
        logic [7:0]             code_byte;
        logic [CODE_IDX_W-1:0]  code_index;
        logic [2:0]             status;
        logic [FRAME_LEN_W-1:0] frame_length;
    } t_result;

    // handoff from the frame logic to the result register
    typedef struct packed {
        logic    load;
        t_result data;
    } t_res_xfer;

endpackage

// File: hw/rtl/upr_in_if.sv
// input channel: received bytes and millisecond ticks
interface upr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// File: hw/rtl/upr_out_if.sv
// output channel: code bytes and frame status
interface upr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  code_byte;
    logic [9:0]  code_index;
    logic [2:0]  status;
    logic [10:0] frame_length;

    modport source (output valid, output kind, output code_byte, output code_index,
                    output status, output frame_length, input ready);
    modport sink   (input valid, input kind, input code_byte, input code_index,
                    input status, input frame_length, output ready);
endinterface

// File: hw/rtl/upr_cfg_if.sv
// configuration write channel
interface upr_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/upload_frame_receiver_top.sv
// top level of the upload frame receiver
//
//  channel   dir  payload                                           handshake
//  i_cmd     in   operation, rx_byte                                valid/ready
//  o_res     out  kind, code_byte, code_index, status, frame_length valid/ready
//  i_cfg     in   index (0 hunt window, 1 byte wait), data          valid/ready, always ready
//
// one transaction per cycle while o_res is not stalled: input register, combinational frame logic, result register
// a result is loaded into the result register as the frame logic consumes its input transaction
// i_rst_n is synchronous; it clears the frame state and loads the default register values
// a stalled output holds its result; a transaction waiting in the input register then
// holds i_cmd.ready low in the same cycle, since ready follows o_res.ready combinationally
module upload_frame_receiver_top
    import upr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    upr_in_if.sink      i_cmd,
    upr_cfg_if.sink     i_cfg,
    upr_out_if.source   o_res
);

    logic [31:0] hunt_window;
    logic [15:0] byte_wait;
    logic        out_free;
    t_res_xfer   res_xfer;

    upr_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .o_hunt_window (hunt_window),
        .o_byte_wait   (byte_wait)
    );

    upr_frame_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_hunt_window (hunt_window),
        .i_byte_wait   (byte_wait),
        .i_out_free    (out_free),
        .o_res         (res_xfer)
    );

    upr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res_xfer),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

// File: hw/rtl/upr_cfg_regs.sv
// configuration registers: hunt window and inter-byte wait
module upr_cfg_regs
    import upr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    upr_cfg_if.sink      i_cfg,
    output logic [31:0]  o_hunt_window,
    output logic [15:0]  o_byte_wait
);

    logic [31:0] r_hunt_window;
    logic [15:0] r_byte_wait;
    logic        cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt_window <= HUNT_WINDOW_RST;
            r_byte_wait   <= BYTE_WAIT_RST;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_HUNT_WINDOW: r_hunt_window <= i_cfg.data;
                CFG_BYTE_WAIT:   r_byte_wait   <= i_cfg.data[15:0];
                default:         r_hunt_window <= r_hunt_window;
            endcase
        end
    end

    assign o_hunt_window = r_hunt_window;
    assign o_byte_wait   = r_byte_wait;

endmodule

// File: hw/rtl/upr_frame_fsm.sv
// input register, frame state machine and result generation
module upr_frame_fsm
    import upr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    upr_in_if.sink       i_cmd,
    input  logic [31:0]  i_hunt_window,
    input  logic [15:0]  i_byte_wait,
    input  logic         i_out_free,
    output t_res_xfer    o_res
);

    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_byte;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count,  n_count;
    logic [7:0]  r_sum,    n_sum;
    logic [31:0] r_elapsed, n_elapsed;

    logic        advance;
    logic        res_valid;
    t_result     res;
    logic [31:0] elapsed_inc;
    logic [15:0] count_inc;
    logic [15:0] len_new;
    logic        hunt_open;

    assign advance     = r_in_valid && i_out_free;
    assign i_cmd.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_op   <= i_cmd.operation;
            r_in_byte <= i_cmd.rx_byte;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_len_lo  <= '0;
            r_length  <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_elapsed <= '0;
        end else begin
            r_phase   <= n_phase;
            r_len_lo  <= n_len_lo;
            r_length  <= n_length;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_elapsed <= n_elapsed;
        end
    end

    assign elapsed_inc = (r_elapsed == HUNT_FOREVER) ? r_elapsed : r_elapsed + 32'd1;
    assign count_inc   = r_count + 16'd1;
    assign len_new     = {r_in_byte, r_len_lo};
    assign hunt_open   = (i_hunt_window == HUNT_FOREVER);

    always_comb begin
        n_phase   = r_phase;
        n_len_lo  = r_len_lo;
        n_length  = r_length;
        n_count   = r_count;
        n_sum     = r_sum;
        n_elapsed = r_elapsed;
        res_valid = 1'b0;
        res       = '0;

        if (advance) begin
            if (t_op'(r_in_op) == OP_TICK) begin
                n_elapsed = elapsed_inc;
                if (r_phase == PH_HUNT) begin
                    if (!hunt_open && elapsed_inc >= i_hunt_window) begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_NOSTART;
                    end
                end else if (elapsed_inc >= {16'd0, i_byte_wait}) begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_STATUS;
                    res.status = ST_TIMEOUT;
                end
            end else begin
                if (r_phase != PH_HUNT) begin
                    n_elapsed = '0;
                end
                unique case (r_phase)
                    PH_HUNT: begin
                        if (!hunt_open && r_elapsed >= i_hunt_window) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_STATUS;
                            res.status = ST_NOSTART;
                        end else if (r_in_byte == CH_T) begin
                            n_phase   = PH_MAG_V;
                            n_elapsed = '0;
                        end
                    end
                    PH_MAG_V, PH_MAG_M, PH_MAG_1: begin
                        if ((r_phase == PH_MAG_V && r_in_byte != CH_V) ||
                            (r_phase == PH_MAG_M && r_in_byte != CH_M) ||
                            (r_phase == PH_MAG_1 && r_in_byte != CH_ONE)) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_STATUS;
                            res.status = ST_MAGIC;
                        end else begin
                            n_phase = t_phase'(r_phase + 3'd1);
                        end
                    end
                    PH_LEN_LO: begin
                        n_len_lo = r_in_byte;
                        n_phase  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_length = len_new;
                        if (len_new == 16'd0 || len_new > CODE_MAX) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_STATUS;
                            res.status = ST_LENGTH;
                        end else begin
                            n_count = '0;
                            n_sum   = '0;
                            n_phase = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CODE;
                        res.code_byte  = r_in_byte;
                        res.code_index = r_count[CODE_IDX_W-1:0];
                        n_sum          = r_sum + r_in_byte;
                        n_count        = count_inc;
                        if (count_inc >= r_length) begin
                            n_phase = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_STATUS;
                        if (r_in_byte != r_sum) begin
                            res.status = ST_SUM;
                        end else begin
                            res.status       = ST_OK;
                            res.frame_length = r_length[FRAME_LEN_W-1:0];
                        end
                    end
                endcase
            end

            // every status ends the attempt and restarts the hunt
            if (res_valid && t_kind'(res.kind) == KIND_STATUS) begin
                n_phase   = PH_HUNT;
                n_len_lo  = '0;
                n_length  = '0;
                n_count   = '0;
                n_sum     = '0;
                n_elapsed = '0;
            end
        end
    end

    assign o_res.load = advance && res_valid;
    assign o_res.data = res;

    a_status_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.load && o_res.data.kind == KIND_STATUS) |=> (r_phase == PH_HUNT && r_elapsed == '0))
        else $error("status did not restart the hunt");

    a_code_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CODE) |-> (r_count < r_length && r_length <= CODE_MAX))
        else $error("code byte count out of range");

    a_sum_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SUM) |-> (r_count == r_length && r_length != 16'd0))
        else $error("checksum phase with wrong byte count");

    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.load && o_res.data.kind == KIND_STATUS && o_res.data.status == ST_OK)
            |-> (o_res.data.frame_length != '0))
        else $error("ok status without length");

endmodule

// File: hw/rtl/upr_out_stage.sv
// result register toward the output channel
module upr_out_stage
    import upr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_res_xfer   i_res,
    output logic        o_free,
    upr_out_if.source   o_res
);

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.load) begin
            r_data <= i_res.data;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_data.kind;
    assign o_res.code_byte    = r_data.code_byte;
    assign o_res.code_index   = r_data.code_index;
    assign o_res.status       = r_data.status;
    assign o_res.frame_length = r_data.frame_length;

endmodule

// File: tb/tb_upload_frame_receiver_top.sv
// testbench for the upload frame receiver: byte and tick streams checked against a frame predictor
module tb_upload_frame_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import upr_pkg::*;

    localparam int unsigned RUN_LIMIT   = 300000;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned TOTAL_ITEMS = 1850;
    localparam int unsigned MAX_PRINTS  = 100;

    typedef struct packed {
        t_op        op;
        logic [7:0] b;
    } t_rx_event;

    logic i_clk;
    logic i_rst_n;

    upr_in_if  cmd_if ();
    upr_cfg_if cfg_if ();
    upr_out_if res_if ();

    upload_frame_receiver_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    t_rx_event   event_q[$];
    t_result     expected_q[$];
    int unsigned queued_items = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned send_gap_pct = 33;
    int unsigned stall_pct    = 33;
    logic        cmd_taken    = 1'b0;

    // frame predictor state and its copy of the registers
    t_phase      frame_phase;
    logic [7:0]  len_low;
    logic [15:0] frame_len;
    logic [15:0] code_count;
    logic [7:0]  code_sum;
    logic [31:0] tick_count;
    logic [31:0] hunt_window;
    logic [15:0] byte_wait;

    logic [7:0]  magic_seq [3] = '{CH_V, CH_M, CH_ONE};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTS) $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic clear_frame();
        frame_phase = PH_HUNT;
        len_low     = '0;
        frame_len   = '0;
        code_count  = '0;
        code_sum    = '0;
        tick_count  = '0;
    endtask

    task automatic end_attempt(t_status st, logic [10:0] n);
        t_result r;
        r              = '0;
        r.kind         = KIND_STATUS;
        r.status       = st;
        r.frame_length = n;
        expected_q.push_back(r);
        clear_frame();
    endtask

    function automatic bit hunt_over();
        return hunt_window != HUNT_FOREVER && tick_count >= hunt_window;
    endfunction

    // advance the frame predictor by one accepted event
    task automatic frame_step(logic op, logic [7:0] b);
        t_result r;
        if (op == OP_TICK) begin
            if (tick_count != '1) tick_count++;
            if (frame_phase == PH_HUNT) begin
                if (hunt_over()) end_attempt(ST_NOSTART, '0);
            end else if (tick_count >= {16'd0, byte_wait}) begin
                end_attempt(ST_TIMEOUT, '0);
            end
        end else if (frame_phase == PH_HUNT) begin
            // an expired window swallows the byte, even a start byte
            if (hunt_over()) begin
                end_attempt(ST_NOSTART, '0);
            end else if (b == CH_T) begin
                frame_phase = PH_MAG_V;
                tick_count  = '0;
            end
        end else begin
            tick_count = '0;
            case (frame_phase)
                PH_MAG_V: begin
                    if (b != CH_V) end_attempt(ST_MAGIC, '0);
                    else frame_phase = PH_MAG_M;
                end
                PH_MAG_M: begin
                    if (b != CH_M) end_attempt(ST_MAGIC, '0);
                    else frame_phase = PH_MAG_1;
                end
                PH_MAG_1: begin
                    if (b != CH_ONE) end_attempt(ST_MAGIC, '0);
                    else frame_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_low     = b;
                    frame_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    frame_len = {b, len_low};
                    if (frame_len == '0 || frame_len > CODE_MAX) begin
                        end_attempt(ST_LENGTH, '0);
                    end else begin
                        code_count  = '0;
                        code_sum    = '0;
                        frame_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    r            = '0;
                    r.kind       = KIND_CODE;
                    r.code_byte  = b;
                    r.code_index = code_count[CODE_IDX_W-1:0];
                    expected_q.push_back(r);
                    code_sum   = code_sum + b;
                    code_count = code_count + 16'd1;
                    if (code_count >= frame_len) frame_phase = PH_SUM;
                end
                default: begin
                    if (b != code_sum) end_attempt(ST_SUM, '0);
                    else end_attempt(ST_OK, frame_len[FRAME_LEN_W-1:0]);
                end
            endcase
        end
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_result();
        t_result want;
        if (expected_q.size() == 0) begin
            report_error("result arrived with nothing expected");
        end else begin
            want = expected_q.pop_front();
            compare_field("kind", 32'(res_if.kind), 32'(want.kind));
            compare_field("code_byte", 32'(res_if.code_byte), 32'(want.code_byte));
            compare_field("code_index", 32'(res_if.code_index), 32'(want.code_index));
            compare_field("status", 32'(res_if.status), 32'(want.status));
            compare_field("frame_length", 32'(res_if.frame_length),
                          32'(want.frame_length));
        end
    endtask

    // stimulus builders
    task automatic add_event(t_op op, logic [7:0] b);
        t_rx_event ev;
        ev.op = op;
        ev.b  = b;
        event_q.push_back(ev);
        queued_items++;
    endtask

    task automatic add_byte(logic [7:0] b);
        add_event(OP_BYTE, b);
    endtask

    task automatic add_ticks(int unsigned n);
        repeat (n) add_event(OP_TICK, 8'($urandom));
    endtask

    task automatic add_header(logic [15:0] n);
        add_byte(CH_T);
        add_byte(CH_V);
        add_byte(CH_M);
        add_byte(CH_ONE);
        add_byte(n[7:0]);
        add_byte(n[15:8]);
    endtask

    // ticks between code bytes stay below tick_max + 1, so a good frame never times out
    task automatic add_frame(int unsigned n, int unsigned tick_max, bit good_sum);
        logic [7:0]  sum;
        logic [7:0]  c;
        int unsigned i;
        sum = '0;
        add_header(16'(n));
        for (i = 0; i < n; i++) begin
            c   = 8'($urandom);
            sum = sum + c;
            if ($urandom_range(7) == 0) add_ticks($urandom_range(tick_max));
            add_byte(c);
        end
        add_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic add_random_sequence();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        logic [7:0]  bad;
        pick = $urandom_range(99);
        if (pick < 60) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            add_frame(n, 32'(byte_wait) - 32'd1, $urandom_range(5) != 0);
        end else if (pick < 70) begin
            // wrong magic byte at a random position
            add_byte(CH_T);
            k = $urandom_range(2);
            if (k > 0) add_byte(CH_V);
            if (k > 1) add_byte(CH_M);
            bad = 8'($urandom);
            if (bad == magic_seq[k]) bad = bad ^ 8'h01;
            add_byte(bad);
        end else if (pick < 78) begin
            add_header($urandom_range(1) ? 16'd0 : 16'($urandom_range(CODE_MAX + 1, 65535)));
        end else if (pick < 86) begin
            // frame cut short, then silence until the byte timer runs out
            n = $urandom_range(1, 8);
            add_header(16'(n));
            repeat ($urandom_range(n - 1)) add_byte(8'($urandom));
            add_ticks(32'(byte_wait));
        end else if (pick < 94) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(3) == 0) add_ticks(1);
                else add_byte(8'($urandom));
            end
        end else begin
            add_ticks($urandom_range(1, hunt_window + 2));
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_HUNT_WINDOW: hunt_window = val;
            CFG_BYTE_WAIT:   byte_wait   = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // let every queued transaction through and every result out
    task automatic wait_idle();
        while (event_q.size() != 0 || cmd_if.valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // driver: event channel
    always @(negedge i_clk) begin
        t_rx_event ev;
        if (!cmd_if.valid || cmd_taken) begin
            if (event_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                ev = event_q.pop_front();
                cmd_if.valid     <= 1'b1;
                cmd_if.operation <= ev.op;
                cmd_if.rx_byte   <= ev.b;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: predict on each accepted event, check each accepted result
    always @(posedge i_clk) begin
        cmd_taken <= cmd_if.valid && cmd_if.ready;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) check_result();
            if (cmd_if.valid && cmd_if.ready) frame_step(cmd_if.operation, cmd_if.rx_byte);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb_upload_frame_receiver_top: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned chunk;
        int unsigned random_goal;
        int unsigned chunk_goal;
        int unsigned i;
        logic [7:0]  part;
        logic [7:0]  psum;

        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_BYTE;
        cmd_if.rx_byte   = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_HUNT_WINDOW;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        hunt_window      = HUNT_WINDOW_RST;
        byte_wait        = BYTE_WAIT_RST;
        clear_frame();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: short windows so every status but a checksum error shows up quickly
        write_reg(CFG_HUNT_WINDOW, 32'd2);
        write_reg(CFG_BYTE_WAIT, 32'd3);
        add_byte(8'h00);
        add_header(16'd1);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(CH_T);
        add_byte(8'h00);
        add_header(CODE_MAX + 16'd1);
        add_byte(CH_T);
        add_ticks(3);
        add_ticks(2);
        wait_idle();

        // zero hunt window ends the hunt on any event; upper data bits are dropped
        write_reg(CFG_HUNT_WINDOW, 32'd0);
        write_reg(CFG_BYTE_WAIT, 32'hFFFF_0000);
        add_byte(CH_T);
        add_ticks(1);
        wait_idle();

        // endless hunt, zero byte wait times out on the first tick in a frame
        write_reg(CFG_HUNT_WINDOW, HUNT_FOREVER);
        add_ticks(3);
        add_byte(CH_T);
        add_ticks(1);
        add_byte(CH_T);
        add_byte(CH_V);
        add_ticks(1);
        wait_idle();

        // longest frame, then zero length and a bad checksum
        write_reg(CFG_HUNT_WINDOW, 32'hFFFF_FFFE);
        write_reg(CFG_BYTE_WAIT, 32'h0000_FFFF);
        add_frame(32'(CODE_MAX), 3, 1'b1);
        add_header(16'd0);
        add_frame(2, 3, 1'b0);
        wait_idle();

        random_goal = TOTAL_ITEMS;
        chunk = 0;
        while (queued_items < random_goal) begin
            send_gap_pct = (chunk % 4 == 2) ? 0 : 33;
            stall_pct    = (chunk % 4 == 2) ? 0 : 33;
            write_reg(CFG_HUNT_WINDOW, $urandom_range(8, 40));
            write_reg(CFG_BYTE_WAIT, $urandom_range(1, 6));
            chunk_goal = queued_items + 150;
            while (queued_items < chunk_goal) add_random_sequence();
            if (chunk == 1) begin
                // sender stops in the middle of a frame until all results are out
                psum = '0;
                add_header(16'd4);
                for (i = 0; i < 4; i++) begin
                    part = 8'($urandom);
                    psum = psum + part;
                    if (i == 2) wait_idle();
                    add_byte(part);
                end
                add_byte(psum);
            end
            wait_idle();
            chunk++;
        end

        send_gap_pct = 33;
        stall_pct    = 33;
        wait_idle();
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("tb_upload_frame_receiver_top: PASS");
        end else begin
            $display("tb_upload_frame_receiver_top: FAIL");
        end
        $finish;
    end

endmodule

// File: upload_frame_receiver_top.f
hw/rtl/upr_pkg.sv
hw/rtl/upr_in_if.sv
hw/rtl/upr_out_if.sv
hw/rtl/upr_cfg_if.sv
hw/rtl/upr_cfg_regs.sv
hw/rtl/upr_frame_fsm.sv
hw/rtl/upr_out_stage.sv
hw/rtl/upload_frame_receiver_top.sv
tb/tb_upload_frame_receiver_top.sv
